### rtl/adjacent_rod_hit_clusterer_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ADJACENT_ROD_HIT_CLUSTERER_MACROS_SVH
`define ADJACENT_ROD_HIT_CLUSTERER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ARHC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ARHC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/arhc_pkg.sv
`default_nettype none
package arhc_pkg;

    typedef enum logic [2:0] {
        FLD_TOF      = 3'd0,
        FLD_XPOS     = 3'd1,
        FLD_XPOS_ADC = 3'd2,
        FLD_LAMP     = 3'd3,
        FLD_RAMP     = 3'd4
    } fld_t;

    localparam logic REG_MAX_TIME = 1'b0;
    localparam logic REG_MAX_X    = 1'b1;

    localparam logic [15:0] MAX_TIME_RESET = 16'd50;
    localparam logic [15:0] MAX_X_RESET    = 16'd500;

    localparam logic [3:0] DIV_LAST_STEP = 4'd15;

    typedef struct packed {
        logic latch;
        logic flush;
        logic start_join;
        logic mul;
        logic sum;
        logic div_step;
        logic wb;
        logic out_acc;
        logic out_hit;
        logic out_last;
    } cmd_t;

    typedef struct packed {
        logic mode;
        logic join_ok;
        logic multi;
        logic div_done;
        logic last_fld;
    } status_t;

endpackage
`default_nettype wire

### rtl/arhc_ctrl.sv
`default_nettype none
module arhc_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  wire logic             out_ready,
    input  wire arhc_pkg::status_t status,
    output arhc_pkg::cmd_t        cmd
);
    import arhc_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_EVAL  = 8'b0000_0010,
        S_MUL   = 8'b0000_0100,
        S_SUM   = 8'b0000_1000,
        S_DIV   = 8'b0001_0000,
        S_WB    = 8'b0010_0000,
        S_OUT1  = 8'b0100_0000,
        S_OUT2  = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT1) || (state_reg == S_OUT2);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (status.mode)
                begin
                    cmd.flush = 1'b1;
                    if (status.multi)
                    begin
                        cmd.out_acc  = 1'b1;
                        cmd.out_last = 1'b1;
                        state_next   = S_OUT2;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
                else if (status.join_ok)
                begin
                    cmd.start_join = 1'b1;
                    state_next     = S_MUL;
                end
                else if (status.multi)
                begin
                    cmd.out_acc = 1'b1;
                    state_next  = S_OUT1;
                end
                else
                begin
                    cmd.out_hit = 1'b1;
                    state_next  = S_OUT2;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_done)
                begin
                    state_next = S_WB;
                end
            end
            S_WB:
            begin
                cmd.wb     = 1'b1;
                state_next = status.last_fld ? S_IDLE : S_MUL;
            end
            S_OUT1:
            begin
                if (out_ready)
                begin
                    cmd.out_hit = 1'b1;
                    state_next  = S_OUT2;
                end
            end
            S_OUT2:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

### rtl/arhc_datapath.sv
`default_nettype none
module arhc_datapath (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic              cfg_index,
    input  wire logic [15:0]       cfg_wdata,
    input  wire logic              mode,
    input  wire logic [2:0]        sector,
    input  wire logic [5:0]        rod,
    input  wire logic signed [15:0] tof,
    input  wire logic signed [15:0] xpos,
    input  wire logic signed [15:0] xpos_adc,
    input  wire logic [15:0]       edep,
    input  wire logic [11:0]       left_amp,
    input  wire logic [11:0]       right_amp,
    input  wire logic              adc_ok,
    input  wire arhc_pkg::cmd_t    cmd,
    output arhc_pkg::status_t      status,
    output logic [2:0]             out_sector,
    output logic [5:0]             out_rod,
    output logic signed [15:0]     out_tof,
    output logic signed [15:0]     out_xpos,
    output logic signed [15:0]     out_xpos_adc,
    output logic [15:0]            out_edep,
    output logic [11:0]            out_left_amp,
    output logic [11:0]            out_right_amp,
    output logic [6:0]             cluster_size,
    output logic                   out_adc_ok,
    output logic                   last_result
);
    import arhc_pkg::*;

    logic [15:0] max_time_reg, max_x_reg;

    logic        h_mode_reg, h_ok_reg;
    logic [2:0]  h_sector_reg;
    logic [5:0]  h_rod_reg;
    logic [15:0] h_tof_reg, h_xpos_reg, h_xpa_reg, h_edep_reg;
    logic [11:0] h_lamp_reg, h_ramp_reg;

    logic        prev_valid_reg;
    logic [2:0]  prev_sector_reg;
    logic [5:0]  prev_rod_reg;
    logic [15:0] prev_tof_reg, prev_xpos_reg;

    logic [2:0]  acc_sector_reg;
    logic [5:0]  acc_rod_reg;
    logic [15:0] acc_tof_reg, acc_xpos_reg, acc_xpa_reg, acc_edep_reg;
    logic [11:0] acc_lamp_reg, acc_ramp_reg;
    logic        acc_ok_reg;
    logic [6:0]  acc_size_reg;

    fld_t        fld_reg;
    logic [15:0] w1_reg, w2_reg;
    logic signed [33:0] p1_reg, p2_reg;
    logic        neg_reg;
    logic [17:0] rem_reg;
    logic [15:0] quo_reg;
    logic [16:0] div_reg;
    logic [3:0]  cnt_reg;

    logic [16:0] dt, dx, adt, adx;
    logic        both_nz;
    logic [16:0] esum;
    logic signed [16:0] op_a, op_h;
    logic signed [34:0] num;
    logic [34:0] mag;
    logic [17:0] trial;
    logic        ge;
    logic [15:0] res;

    assign dt  = {h_tof_reg[15], h_tof_reg} - {prev_tof_reg[15], prev_tof_reg};
    assign dx  = {h_xpos_reg[15], h_xpos_reg} - {prev_xpos_reg[15], prev_xpos_reg};
    assign adt = dt[16] ? (17'd0 - dt) : dt;
    assign adx = dx[16] ? (17'd0 - dx) : dx;

    assign status.mode     = h_mode_reg;
    assign status.join_ok  = prev_valid_reg && (h_sector_reg == prev_sector_reg)
                             && ({1'b0, h_rod_reg} == ({1'b0, prev_rod_reg} + 7'd1))
                             && (adt < {1'b0, max_time_reg})
                             && (adx < {1'b0, max_x_reg});
    assign status.multi    = (acc_size_reg > 7'd1);
    assign status.div_done = (cnt_reg == DIV_LAST_STEP);
    assign status.last_fld = (fld_reg == FLD_RAMP);

    assign both_nz = (acc_edep_reg != 16'd0) && (h_edep_reg != 16'd0);
    assign esum    = {1'b0, acc_edep_reg} + {1'b0, h_edep_reg};

    always_comb
    begin
        case (fld_reg)
            FLD_TOF:
            begin
                op_a = {acc_tof_reg[15], acc_tof_reg};
                op_h = {h_tof_reg[15], h_tof_reg};
            end
            FLD_XPOS:
            begin
                op_a = {acc_xpos_reg[15], acc_xpos_reg};
                op_h = {h_xpos_reg[15], h_xpos_reg};
            end
            FLD_XPOS_ADC:
            begin
                op_a = {acc_xpa_reg[15], acc_xpa_reg};
                op_h = {h_xpa_reg[15], h_xpa_reg};
            end
            FLD_LAMP:
            begin
                op_a = {5'd0, acc_lamp_reg};
                op_h = {5'd0, h_lamp_reg};
            end
            FLD_RAMP:
            begin
                op_a = {5'd0, acc_ramp_reg};
                op_h = {5'd0, h_ramp_reg};
            end
            default:
            begin
                op_a = '0;
                op_h = '0;
            end
        endcase
    end

    assign num   = {p1_reg[33], p1_reg} + {p2_reg[33], p2_reg};
    assign mag   = num[34] ? (35'd0 - num) : num;
    assign trial = {rem_reg[16:0], quo_reg[15]};
    assign ge    = (trial >= {1'b0, div_reg});
    assign res   = neg_reg ? (16'd0 - quo_reg) : quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_time_reg <= MAX_TIME_RESET;
            max_x_reg    <= MAX_X_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_MAX_TIME)
            begin
                max_time_reg <= cfg_wdata;
            end
            else
            begin
                max_x_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            h_mode_reg   <= mode;
            h_sector_reg <= sector;
            h_rod_reg    <= rod;
            h_tof_reg    <= tof;
            h_xpos_reg   <= xpos;
            h_xpa_reg    <= adc_ok ? xpos_adc : 16'd0;
            h_edep_reg   <= edep;
            h_lamp_reg   <= left_amp;
            h_ramp_reg   <= right_amp;
            h_ok_reg     <= adc_ok;
        end
        if (cmd.start_join)
        begin
            w1_reg <= both_nz ? acc_edep_reg : 16'd1;
            w2_reg <= both_nz ? h_edep_reg : 16'd1;
        end
        if (cmd.mul)
        begin
            p1_reg <= op_a * $signed({1'b0, w1_reg});
            p2_reg <= op_h * $signed({1'b0, w2_reg});
        end
        if (cmd.sum)
        begin
            neg_reg <= num[34];
            rem_reg <= mag[33:16];
            quo_reg <= mag[15:0];
            div_reg <= {1'b0, w1_reg} + {1'b0, w2_reg};
            cnt_reg <= 4'd0;
        end
        if (cmd.div_step)
        begin
            rem_reg <= ge ? (trial - {1'b0, div_reg}) : trial;
            quo_reg <= {quo_reg[14:0], ge};
            cnt_reg <= cnt_reg + 4'd1;
        end
        if (cmd.out_acc)
        begin
            out_sector    <= acc_sector_reg;
            out_rod       <= acc_rod_reg;
            out_tof       <= acc_tof_reg;
            out_xpos      <= acc_xpos_reg;
            out_xpos_adc  <= acc_xpa_reg;
            out_edep      <= acc_edep_reg;
            out_left_amp  <= acc_lamp_reg;
            out_right_amp <= acc_ramp_reg;
            cluster_size  <= acc_size_reg;
            out_adc_ok    <= acc_ok_reg;
            last_result   <= cmd.out_last;
        end
        else if (cmd.out_hit)
        begin
            out_sector    <= h_sector_reg;
            out_rod       <= h_rod_reg;
            out_tof       <= h_tof_reg;
            out_xpos      <= h_xpos_reg;
            out_xpos_adc  <= h_xpa_reg;
            out_edep      <= h_edep_reg;
            out_left_amp  <= h_lamp_reg;
            out_right_amp <= h_ramp_reg;
            cluster_size  <= 7'd1;
            out_adc_ok    <= h_ok_reg;
            last_result   <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_valid_reg  <= 1'b0;
            prev_sector_reg <= '0;
            prev_rod_reg    <= '0;
            prev_tof_reg    <= '0;
            prev_xpos_reg   <= '0;
            acc_sector_reg  <= '0;
            acc_rod_reg     <= '0;
            acc_tof_reg     <= '0;
            acc_xpos_reg    <= '0;
            acc_xpa_reg     <= '0;
            acc_edep_reg    <= '0;
            acc_lamp_reg    <= '0;
            acc_ramp_reg    <= '0;
            acc_ok_reg      <= 1'b0;
            acc_size_reg    <= 7'd1;
            fld_reg         <= FLD_TOF;
        end
        else
        begin
            if (cmd.flush)
            begin
                prev_valid_reg <= 1'b0;
                acc_size_reg   <= 7'd1;
            end
            if (cmd.start_join || cmd.out_hit)
            begin
                prev_valid_reg  <= 1'b1;
                prev_sector_reg <= h_sector_reg;
                prev_rod_reg    <= h_rod_reg;
                prev_tof_reg    <= h_tof_reg;
                prev_xpos_reg   <= h_xpos_reg;
            end
            if (cmd.start_join)
            begin
                if (both_nz)
                begin
                    acc_edep_reg <= esum[16] ? 16'hFFFF : esum[15:0];
                end
                acc_ok_reg   <= acc_ok_reg & h_ok_reg;
                acc_size_reg <= acc_size_reg + 7'd1;
                fld_reg      <= FLD_TOF;
            end
            if (cmd.out_hit)
            begin
                acc_sector_reg <= h_sector_reg;
                acc_rod_reg    <= h_rod_reg;
                acc_tof_reg    <= h_tof_reg;
                acc_xpos_reg   <= h_xpos_reg;
                acc_xpa_reg    <= h_xpa_reg;
                acc_edep_reg   <= h_edep_reg;
                acc_lamp_reg   <= h_lamp_reg;
                acc_ramp_reg   <= h_ramp_reg;
                acc_ok_reg     <= h_ok_reg;
                acc_size_reg   <= 7'd1;
            end
            if (cmd.wb)
            begin
                case (fld_reg)
                    FLD_TOF:      acc_tof_reg  <= res;
                    FLD_XPOS:     acc_xpos_reg <= res;
                    FLD_XPOS_ADC: acc_xpa_reg  <= res;
                    FLD_LAMP:     acc_lamp_reg <= res[11:0];
                    FLD_RAMP:     acc_ramp_reg <= res[11:0];
                    default:      acc_tof_reg  <= acc_tof_reg;
                endcase
                unique case (fld_reg)
                    FLD_TOF:      fld_reg <= FLD_XPOS;
                    FLD_XPOS:     fld_reg <= FLD_XPOS_ADC;
                    FLD_XPOS_ADC: fld_reg <= FLD_LAMP;
                    FLD_LAMP:     fld_reg <= FLD_RAMP;
                    default:      fld_reg <= FLD_TOF;
                endcase
            end
        end
    end

endmodule
`default_nettype wire

### rtl/adjacent_rod_hit_clusterer.sv
// Clusters hits on neighboring rods of one sector and reports energy-weighted centroids.
// The input channel (in_valid/in_ready) carries hits in readout order and, with mode set,
// end-of-event markers. The output channel (out_valid/out_ready) carries clusters; each
// input yields zero, one or two results, and last_result marks the final one.
// Every input is transferred in S_IDLE and evaluated in S_EVAL. A hit that joins the open
// cluster then runs five weighted means through one shared multiplier pair and a radix-2
// divider, each through S_MUL, S_SUM, S_DIV and S_WB. Other hits go from S_EVAL to
// S_OUT1/S_OUT2. The block works on one item at a time. The user must write the limit
// registers via cfg_we/cfg_index/cfg_wdata only while idle; the block does not enforce it.
// Reset empties the event history and loads the default limits of 50 and 500.
// While the receiver stalls, the result stays on the outputs and no input is taken.
`default_nettype none
`include "adjacent_rod_hit_clusterer_macros.svh"
module adjacent_rod_hit_clusterer (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic              cfg_index,
    input  wire logic [15:0]       cfg_wdata,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic              mode,
    input  wire logic [2:0]        sector,
    input  wire logic [5:0]        rod,
    input  wire logic signed [15:0] tof,
    input  wire logic signed [15:0] xpos,
    input  wire logic signed [15:0] xpos_adc,
    input  wire logic [15:0]       edep,
    input  wire logic [11:0]       left_amp,
    input  wire logic [11:0]       right_amp,
    input  wire logic              adc_ok,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [2:0]             out_sector,
    output logic [5:0]             out_rod,
    output logic signed [15:0]     out_tof,
    output logic signed [15:0]     out_xpos,
    output logic signed [15:0]     out_xpos_adc,
    output logic [15:0]            out_edep,
    output logic [11:0]            out_left_amp,
    output logic [11:0]            out_right_amp,
    output logic [6:0]             cluster_size,
    output logic                   out_adc_ok,
    output logic                   last_result
);
    import arhc_pkg::*;

    cmd_t    cmd;
    status_t status;

    arhc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    arhc_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .mode          (mode),
        .sector        (sector),
        .rod           (rod),
        .tof           (tof),
        .xpos          (xpos),
        .xpos_adc      (xpos_adc),
        .edep          (edep),
        .left_amp      (left_amp),
        .right_amp     (right_amp),
        .adc_ok        (adc_ok),
        .cmd           (cmd),
        .status        (status),
        .out_sector    (out_sector),
        .out_rod       (out_rod),
        .out_tof       (out_tof),
        .out_xpos      (out_xpos),
        .out_xpos_adc  (out_xpos_adc),
        .out_edep      (out_edep),
        .out_left_amp  (out_left_amp),
        .out_right_amp (out_right_amp),
        .cluster_size  (cluster_size),
        .out_adc_ok    (out_adc_ok),
        .last_result   (last_result)
    );

    `ARHC_ASSERT_SAME(a_no_overlap, out_valid, !in_ready, "input taken while a result is pending")
    `ARHC_ASSERT_NEXT(a_busy_after_in, in_valid && in_ready, !in_ready && !out_valid, "no evaluation cycle after transfer")
    `ARHC_ASSERT_SAME(a_size_nonzero, out_valid, cluster_size != 7'd0, "result with empty cluster")
    `ARHC_ASSERT_NEXT(a_second_last, out_valid && out_ready && !last_result, out_valid && last_result, "first result not followed by last one")

endmodule
`default_nettype wire

### bench/adjacent_rod_hit_clusterer_tb.sv
`timescale 1ns / 1ps
`default_nettype none
module adjacent_rod_hit_clusterer_tb;
    import arhc_pkg::*;

    typedef struct packed {
        logic              mode;
        logic [2:0]        sector;
        logic [5:0]        rod;
        logic signed [15:0] tof;
        logic signed [15:0] xpos;
        logic signed [15:0] xpos_adc;
        logic [15:0]       edep;
        logic [11:0]       left_amp;
        logic [11:0]       right_amp;
        logic              adc_ok;
    } hit_t;

    typedef struct packed {
        logic [2:0]        sector;
        logic [5:0]        rod;
        logic signed [15:0] tof;
        logic signed [15:0] xpos;
        logic signed [15:0] xpos_adc;
        logic [15:0]       edep;
        logic [11:0]       left_amp;
        logic [11:0]       right_amp;
        logic [6:0]        size;
        logic              adc_ok;
        logic              last;
    } cluster_t;

    typedef struct {
        hit_t     hit;
        logic     has_exp;
        cluster_t exp0;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic cfg_index = REG_MAX_TIME;
    logic [15:0] cfg_wdata = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    hit_t drv = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    cluster_t got;

    always #2 clk = ~clk;

    adjacent_rod_hit_clusterer u_top (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_ready(in_ready),
        .mode(drv.mode), .sector(drv.sector), .rod(drv.rod), .tof(drv.tof),
        .xpos(drv.xpos), .xpos_adc(drv.xpos_adc), .edep(drv.edep),
        .left_amp(drv.left_amp), .right_amp(drv.right_amp), .adc_ok(drv.adc_ok),
        .out_valid(out_valid), .out_ready(out_ready),
        .out_sector(got.sector), .out_rod(got.rod), .out_tof(got.tof),
        .out_xpos(got.xpos), .out_xpos_adc(got.xpos_adc), .out_edep(got.edep),
        .out_left_amp(got.left_amp), .out_right_amp(got.right_amp),
        .cluster_size(got.size), .out_adc_ok(got.adc_ok), .last_result(got.last)
    );

    // Predictor state.
    logic [15:0] lim_time, lim_x;
    logic        hist_valid;
    logic [2:0]  hist_sector;
    logic [5:0]  hist_rod;
    logic signed [15:0] hist_tof, hist_xpos;
    cluster_t    open_cl;

    cluster_t expected_clusters[$];
    int  errors = 0;
    int  cycles = 0;
    logic stall_free = 1'b0;

    function automatic longint wavg(longint a, longint h, longint w1, longint w2);
        return (a * w1 + h * w2) / (w1 + w2);
    endfunction

    task automatic predict_clusters(input hit_t h);
        longint w1, w2, adt, adx;
        logic joins;
        cluster_t c;
        w1 = 1;
        w2 = 1;
        if (h.mode)
        begin
            if (open_cl.size > 1)
            begin
                c = open_cl;
                c.last = 1'b1;
                expected_clusters.push_back(c);
            end
            hist_valid = 1'b0;
            open_cl.size = 1;
            return;
        end
        if (!h.adc_ok)
            h.xpos_adc = '0;
        adt = longint'(h.tof) - longint'(hist_tof);
        adx = longint'(h.xpos) - longint'(hist_xpos);
        if (adt < 0) adt = -adt;
        if (adx < 0) adx = -adx;
        joins = hist_valid && h.sector == hist_sector && {1'b0, h.rod} == hist_rod + 7'd1
                && adt < lim_time && adx < lim_x;
        if (joins)
        begin
            if (open_cl.edep != 0 && h.edep != 0)
            begin
                w1 = open_cl.edep;
                w2 = h.edep;
                open_cl.edep = (w1 + w2 > 65535) ? 16'hFFFF : 16'(w1 + w2);
            end
            open_cl.tof = 16'(wavg(open_cl.tof, h.tof, w1, w2));
            open_cl.xpos = 16'(wavg(open_cl.xpos, h.xpos, w1, w2));
            open_cl.xpos_adc = 16'(wavg(open_cl.xpos_adc, h.xpos_adc, w1, w2));
            open_cl.left_amp = 12'(wavg(open_cl.left_amp, h.left_amp, w1, w2));
            open_cl.right_amp = 12'(wavg(open_cl.right_amp, h.right_amp, w1, w2));
            open_cl.adc_ok = open_cl.adc_ok & h.adc_ok;
            open_cl.size = open_cl.size + 7'd1;
        end
        else
        begin
            if (open_cl.size > 1)
            begin
                c = open_cl;
                c.last = 1'b0;
                expected_clusters.push_back(c);
            end
            open_cl = '{h.sector, h.rod, h.tof, h.xpos, h.xpos_adc, h.edep,
                        h.left_amp, h.right_amp, 7'd1, h.adc_ok, 1'b1};
            expected_clusters.push_back(open_cl);
        end
        hist_valid = 1'b1;
        hist_sector = h.sector;
        hist_rod = h.rod;
        hist_tof = h.tof;
        hist_xpos = h.xpos;
    endtask

    task automatic write_limit(input logic idx, input logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_MAX_TIME) lim_time = val;
        else lim_x = val;
        @(posedge clk);
    endtask

    task automatic settle;
        while (expected_clusters.size() != 0)
            @(posedge clk);
        repeat (120) @(posedge clk);
    endtask

    task automatic send_hit(input hit_t h);
        while (!stall_free && $urandom_range(99) < 12)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        drv <= h;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_clusters(h);
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic hit_t random_hit();
        hit_t h;
        h = hit_t'({$urandom, $urandom, $urandom, $urandom});
        h.mode = ($urandom_range(99) < 6);
        h.sector = 3'($urandom_range(7));
        return h;
    endfunction

    function automatic hit_t next_neighbor(input hit_t p);
        hit_t h;
        h = random_hit();
        h.mode = 1'b0;
        h.sector = p.sector;
        h.rod = p.rod + 6'd1;
        h.tof = p.tof + $signed(16'($urandom_range(80))) - 16'sd40;
        h.xpos = p.xpos + $signed(16'($urandom_range(800))) - 16'sd400;
        if ($urandom_range(3) == 0) h.edep = 16'($urandom_range(3));
        return h;
    endfunction

    // Compare every result transfer with the oldest expected cluster.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_clusters.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %p", $time, got);
                errors++;
            end
            else if (got !== expected_clusters[0])
            begin
                $display("%0t: mismatch, expected %p, actual %p", $time,
                         expected_clusters[0], got);
                errors++;
                void'(expected_clusters.pop_front());
            end
            else
                void'(expected_clusters.pop_front());
        end
    end

    always @(posedge clk)
    begin
        out_ready <= stall_free || ($urandom_range(99) >= 12);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 900000)
        begin
            $display("FAIL");
            $finish;
        end
    end

    stim_row_t rows[$];
    hit_t h, p;
    int n, k;

    initial
    begin
        lim_time = MAX_TIME_RESET;
        lim_x = MAX_X_RESET;
        hist_valid = 1'b0;
        hist_sector = '0;
        hist_rod = '0;
        hist_tof = '0;
        hist_xpos = '0;
        open_cl = '0;
        open_cl.size = 7'd1;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table: extremes, joins, saturation, invalid ADC positions, rod wrap.
        rows.push_back('{'{1'b0, 3'd0, 6'd0, -16'sd32768, -16'sd32768, 16'sh7FFF,
            16'hFFFF, 12'hFFF, 12'hFFF, 1'b1}, 1'b1, '{3'd0, 6'd0, -16'sd32768,
            -16'sd32768, 16'sh7FFF, 16'hFFFF, 12'hFFF, 12'hFFF, 7'd1, 1'b1, 1'b1}});
        rows.push_back('{'{1'b0, 3'd0, 6'd1, -16'sd32760, -16'sd32700, 16'sh7000,
            16'hFFFF, 12'd0, 12'd0, 1'b1}, 1'b0, '0});
        rows.push_back('{'{1'b0, 3'd0, 6'd2, -16'sd32750, -16'sd32650, 16'sd5,
            16'd0, 12'd9, 12'd3, 1'b0}, 1'b0, '0});
        rows.push_back('{'{1'b1, 3'd7, 6'd63, 16'sd0, 16'sd0, 16'sd0, 16'd0, 12'd0,
            12'd0, 1'b1}, 1'b0, '0});
        rows.push_back('{'{1'b0, 3'd7, 6'd63, 16'sd32767, 16'sd32767, -16'sd32768,
            16'd0, 12'd0, 12'd4095, 1'b0}, 1'b1, '{3'd7, 6'd63, 16'sd32767,
            16'sd32767, 16'sd0, 16'd0, 12'd0, 12'd4095, 7'd1, 1'b0, 1'b1}});
        rows.push_back('{'{1'b0, 3'd7, 6'd0, 16'sd32767, 16'sd32767, 16'sd1,
            16'd1, 12'd1, 12'd1, 1'b1}, 1'b1, '{3'd7, 6'd0, 16'sd32767,
            16'sd32767, 16'sd1, 16'd1, 12'd1, 12'd1, 7'd1, 1'b1, 1'b1}});
        rows.push_back('{'{1'b0, 3'd6, 6'd1, 16'sd32760, 16'sd32760, 16'sd2,
            16'd3, 12'd2, 12'd2, 1'b1}, 1'b0, '0});
        rows.push_back('{'{1'b0, 3'd5, 6'd2, 16'sd10, 16'sd10, 16'sd2,
            16'd3, 12'd2, 12'd2, 1'b1}, 1'b0, '0});
        rows.push_back('{'{1'b0, 3'd5, 6'd3, 16'sd59, 16'sd509, -16'sd7,
            16'd1, 12'd100, 12'd7, 1'b1}, 1'b0, '0});
        rows.push_back('{'{1'b0, 3'd5, 6'd4, 16'sd110, 16'sd509, -16'sd7,
            16'd1, 12'd100, 12'd7, 1'b1}, 1'b0, '0});
        rows.push_back('{'{1'b1, 3'd0, 6'd0, 16'sd0, 16'sd0, 16'sd0, 16'd0, 12'd0,
            12'd0, 1'b0}, 1'b0, '0});
        rows.push_back('{'{1'b1, 3'd0, 6'd0, 16'sd0, 16'sd0, 16'sd0, 16'd0, 12'd0,
            12'd0, 1'b0}, 1'b0, '0});
        foreach (rows[i])
        begin
            send_hit(rows[i].hit);
            if (rows[i].has_exp && rows[i].exp0 !== expected_clusters[$])
            begin
                $display("%0t: table row %0d, expected %p, actual %p", $time, i,
                         rows[i].exp0, expected_clusters[$]);
                errors++;
            end
        end
        settle();

        // A zero limit keeps every hit apart; then the widest limits.
        write_limit(REG_MAX_TIME, 16'd0);
        write_limit(REG_MAX_X, 16'hFFFF);
        send_hit('{1'b0, 3'd1, 6'd4, 16'sd0, 16'sd0, 16'sd0, 16'd5, 12'd1, 12'd1, 1'b1});
        send_hit('{1'b0, 3'd1, 6'd5, 16'sd0, 16'sd0, 16'sd0, 16'd5, 12'd1, 12'd1, 1'b1});
        settle();
        write_limit(REG_MAX_TIME, 16'hFFFF);
        send_hit('{1'b0, 3'd1, 6'd6, 16'sd32767, 16'sd32767, 16'sd0, 16'd5, 12'd1,
                   12'd1, 1'b1});
        send_hit('{1'b0, 3'd1, 6'd7, -16'sd32768, -16'sd32768, 16'sd0, 16'd9, 12'd1,
                   12'd1, 1'b1});
        send_hit('{1'b1, 3'd0, 6'd0, 16'sd0, 16'sd0, 16'sd0, 16'd0, 12'd0, 12'd0, 1'b0});
        settle();

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin write_limit(REG_MAX_TIME, 16'd50); write_limit(REG_MAX_X, 16'd500); end
                1: begin write_limit(REG_MAX_TIME, 16'd1); write_limit(REG_MAX_X, 16'd1); end
                2: begin write_limit(REG_MAX_TIME, 16'd30); write_limit(REG_MAX_X, 16'd300); end
                default: begin write_limit(REG_MAX_TIME, 16'hFFFF);
                               write_limit(REG_MAX_X, 16'hFFFF); end
            endcase
            stall_free = (phase == 2);
            n = 0;
            while (n < 300)
            begin
                if ($urandom_range(9) < 8)
                begin
                    p = random_hit();
                    p.mode = 1'b0;
                    if ($urandom_range(3) == 0) p.rod = 6'($urandom_range(58, 63));
                    send_hit(p);
                    n++;
                    k = $urandom_range(6);
                    for (int j = 0; j < k; j++)
                    begin
                        h = next_neighbor(p);
                        if ($urandom_range(19) == 0) h.sector = h.sector + 3'd1;
                        send_hit(h);
                        p = h;
                        n++;
                    end
                    if ($urandom_range(1))
                    begin
                        h = random_hit();
                        h.mode = 1'b1;
                        send_hit(h);
                    end
                end
                else
                begin
                    send_hit(random_hit());
                    n++;
                end
                if (n > 150 && n < 160)
                    while (expected_clusters.size() != 0)
                        @(posedge clk);
            end
            settle();
        end

        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
`default_nettype wire

### sim.f
+incdir+rtl
rtl/arhc_pkg.sv
rtl/arhc_ctrl.sv
rtl/arhc_datapath.sv
rtl/adjacent_rod_hit_clusterer.sv
bench/adjacent_rod_hit_clusterer_tb.sv
